/* src/ihex_pkg.sv */
`default_nettype none
//----------------------------------------------------------------------------
// ihex_pkg
// Shared widths, character codes and item types of the hex record parser.
//----------------------------------------------------------------------------
package ihex_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam int CH_W    = 8;
   localparam int VALUE_W = 5;
   localparam int PAIR_W  = 9;
   localparam int POS_W   = 10;
   localparam int ADDR_W  = 21;
   localparam int DATA_W  = 8;
   localparam int SIZE_W  = 22;

   localparam logic CMD_END    = 1'b1;
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_END   = 1'b1;

   localparam logic [CH_W-1:0] CH_NUL     = 8'h00;
   localparam logic [CH_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CH_W-1:0] CH_COLON   = 8'h3A;

   localparam logic [SIZE_W-1:0] MEM_SIZE_RESET = 22'h010000;

   typedef struct packed {
      logic               cmd;
      logic               newline;
      logic               nul;
      logic               colon;
      logic               alnum;
      logic [VALUE_W-1:0] value;
   } char_item_type;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] data;
      logic [SIZE_W-1:0] size;
      logic              error;
   } rsp_item_type;

endpackage
`default_nettype wire

/* src/ihex_fifo.sv */
`default_nettype none
//----------------------------------------------------------------------------
// ihex_fifo
// Small first-in first-out queue with full and empty flags.
//----------------------------------------------------------------------------
module ihex_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rd_data,
   output logic                  empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

/* src/ihex_front.sv */
`default_nettype none
//----------------------------------------------------------------------------
// ihex_front
// Classifies each incoming character: newline, nul, colon, alphanumeric
// and its hex digit value.
//----------------------------------------------------------------------------
module ihex_front (
   input  wire logic                        req_push,
   input  wire logic                        req_cmd,
   input  wire logic [ihex_pkg::CH_W-1:0]   req_ch,
   output logic                             item_push,
   output ihex_pkg::char_item_type          item
);
   import ihex_pkg::*;

   localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [VALUE_W-1:0] LETTER_BIAS = 5'd9;

   logic is_digit;
   logic is_letter;

   assign is_digit  = (req_ch >= CH_ZERO) && (req_ch <= CH_NINE);
   assign is_letter = ((req_ch >= CH_UPPER_A) && (req_ch <= CH_UPPER_Z)) ||
                      ((req_ch >= CH_LOWER_A) && (req_ch <= CH_LOWER_Z));

   assign item_push    = req_push;
   assign item.cmd     = req_cmd;
   assign item.newline = (req_ch == CH_NEWLINE);
   assign item.nul     = (req_ch == CH_NUL);
   assign item.colon   = (req_ch == CH_COLON);
   assign item.alnum   = is_digit || is_letter;
   assign item.value   = is_digit ? {1'b0, req_ch[3:0]}
                                  : {1'b0, req_ch[3:0]} + LETTER_BIAS;

endmodule
`default_nettype wire

/* src/ihex_back.sv */
`default_nettype none
//----------------------------------------------------------------------------
// ihex_back
// Record state machine: walks each line's header, tracks the segment base,
// issues memory writes and the end report, and holds the size register.
//----------------------------------------------------------------------------
module ihex_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ihex_pkg::SIZE_W-1:0]   csr_mem_size,
   input  wire ihex_pkg::char_item_type       char_item,
   input  wire logic                          char_empty,
   output logic                               char_pop,
   input  wire logic                          rsp_full,
   output logic                               rsp_push,
   output ihex_pkg::rsp_item_type             rsp_item
);
   import ihex_pkg::*;

   localparam int PW   = ADDR_W + 1;
   localparam int CMPW = (PW > SIZE_W) ? PW : SIZE_W;

   localparam logic [POS_W-1:0] POS_MARK    = 10'd0;
   localparam logic [POS_W-1:0] POS_LEN_HI  = 10'd1;
   localparam logic [POS_W-1:0] POS_LEN_LO  = 10'd2;
   localparam logic [POS_W-1:0] POS_ADDR_HI = 10'd4;
   localparam logic [POS_W-1:0] POS_ADDR_LO = 10'd6;
   localparam logic [POS_W-1:0] POS_TYPE    = 10'd8;
   localparam logic [POS_W-1:0] POS_SEG_HI  = 10'd10;
   localparam logic [POS_W-1:0] POS_SEG_LO  = 10'd12;
   localparam logic [POS_W-1:0] POS_MAX     = 10'd1023;

   localparam logic [PAIR_W-1:0] REC_DATA    = 9'd0;
   localparam logic [PAIR_W-1:0] REC_SEGMENT = 9'd2;

   logic [POS_W-1:0]     line_position_ff, line_position_in;
   logic                 line_ignored_ff, line_ignored_in;
   logic [PAIR_W-1:0]    pair_count_ff, pair_count_in;
   logic [PAIR_W-1:0]    offset_hi_ff, offset_hi_in;
   logic [PAIR_W-1:0]    record_type_ff, record_type_in;
   logic [VALUE_W-1:0]   high_digit_ff, high_digit_in;
   logic [ADDR_W-1:0]    segment_base_ff, segment_base_in;
   logic [PW-1:0]        write_pointer_ff, write_pointer_in;
   logic [SIZE_W-1:0]    highest_plus_one_ff, highest_plus_one_in;
   logic                 error_latched_ff, error_latched_in;
   logic [SIZE_W-1:0]    mem_size_ff;

   logic                 fire;
   logic [PAIR_W-1:0]    pair;
   logic [16:0]          offset_full;
   logic [PW-1:0]        start_sum;
   logic [CMPW-1:0]      sum_ext;
   logic [CMPW-1:0]      size_ext;
   logic [CMPW-1:0]      wp_ext;
   logic [SIZE_W-1:0]    wp_plus_one;
   logic [ADDR_W-1:0]    seg_scaled;

   assign csr_ready   = 1'b1;
   assign fire        = !char_empty && !rsp_full;
   assign char_pop    = fire;

   assign pair        = {high_digit_ff, 4'h0} + {4'h0, char_item.value};
   assign offset_full = {offset_hi_ff, 8'h00} + {8'h00, pair};
   assign start_sum   = PW'(segment_base_ff) + PW'(offset_full);
   assign sum_ext     = CMPW'(start_sum);
   assign size_ext    = CMPW'(mem_size_ff);
   assign wp_ext      = CMPW'(write_pointer_ff);
   assign wp_plus_one = wp_ext[SIZE_W-1:0] + SIZE_W'(1);
   assign seg_scaled  = {offset_full, 4'h0};

   always_comb begin
      line_position_in    = line_position_ff;
      line_ignored_in     = line_ignored_ff;
      pair_count_in       = pair_count_ff;
      offset_hi_in        = offset_hi_ff;
      record_type_in      = record_type_ff;
      high_digit_in       = high_digit_ff;
      segment_base_in     = segment_base_ff;
      write_pointer_in    = write_pointer_ff;
      highest_plus_one_in = highest_plus_one_ff;
      error_latched_in    = error_latched_ff;
      rsp_push            = 1'b0;
      rsp_item            = '0;

      if (fire) begin
         if (char_item.cmd == CMD_END) begin
            rsp_push            = 1'b1;
            rsp_item.kind       = KIND_END;
            rsp_item.size       = error_latched_ff ? '0 : highest_plus_one_ff;
            rsp_item.error      = error_latched_ff;
            line_position_in    = '0;
            line_ignored_in     = 1'b0;
            pair_count_in       = '0;
            offset_hi_in        = '0;
            record_type_in      = '0;
            high_digit_in       = '0;
            segment_base_in     = '0;
            write_pointer_in    = '0;
            highest_plus_one_in = '0;
            error_latched_in    = 1'b0;
         end else if (error_latched_ff) begin
            // everything waits for the end item
         end else if (char_item.newline) begin
            line_position_in = '0;
            line_ignored_in  = 1'b0;
         end else if (line_ignored_ff) begin
            // rest of line skipped
         end else if (char_item.nul) begin
            line_ignored_in = 1'b1;
         end else if (line_position_ff != POS_MAX) begin
            line_position_in = line_position_ff + POS_W'(1);
            case (line_position_ff)
               POS_MARK: begin
                  if (!char_item.colon) begin
                     line_ignored_in = 1'b1;
                  end
               end
               POS_LEN_HI: begin
                  if (!char_item.alnum) begin
                     line_ignored_in = 1'b1;
                  end else begin
                     high_digit_in = char_item.value;
                  end
               end
               POS_LEN_LO: begin
                  if (!char_item.alnum) begin
                     line_ignored_in = 1'b1;
                  end else begin
                     pair_count_in = pair;
                  end
               end
               POS_ADDR_HI: begin
                  offset_hi_in = pair;
               end
               POS_ADDR_LO: begin
                  if (sum_ext > size_ext) begin
                     error_latched_in = 1'b1;
                  end else begin
                     write_pointer_in = start_sum;
                  end
               end
               POS_TYPE: begin
                  record_type_in = pair;
                  if (pair != REC_DATA && pair != REC_SEGMENT) begin
                     line_ignored_in = 1'b1;
                  end
               end
               default: begin
                  if (line_position_ff[0]) begin
                     high_digit_in = char_item.value;
                  end else if (record_type_ff == REC_SEGMENT) begin
                     if (line_position_ff == POS_SEG_HI) begin
                        offset_hi_in = pair;
                     end else if (line_position_ff == POS_SEG_LO) begin
                        segment_base_in = seg_scaled;
                        line_ignored_in = 1'b1;
                     end
                  end else if (pair_count_ff != '0) begin
                     pair_count_in    = pair_count_ff - PAIR_W'(1);
                     write_pointer_in = write_pointer_ff + PW'(1);
                     if (wp_ext < size_ext) begin
                        if (wp_plus_one > highest_plus_one_ff) begin
                           highest_plus_one_in = wp_plus_one;
                        end
                        rsp_push         = 1'b1;
                        rsp_item.kind    = KIND_WRITE;
                        rsp_item.address = wp_ext[ADDR_W-1:0];
                        rsp_item.data    = pair[DATA_W-1:0];
                     end
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_position_ff    <= '0;
         line_ignored_ff     <= 1'b0;
         pair_count_ff       <= '0;
         offset_hi_ff        <= '0;
         record_type_ff      <= '0;
         high_digit_ff       <= '0;
         segment_base_ff     <= '0;
         write_pointer_ff    <= '0;
         highest_plus_one_ff <= '0;
         error_latched_ff    <= 1'b0;
         mem_size_ff         <= MEM_SIZE_RESET;
      end else begin
         line_position_ff    <= line_position_in;
         line_ignored_ff     <= line_ignored_in;
         pair_count_ff       <= pair_count_in;
         offset_hi_ff        <= offset_hi_in;
         record_type_ff      <= record_type_in;
         high_digit_ff       <= high_digit_in;
         segment_base_ff     <= segment_base_in;
         write_pointer_ff    <= write_pointer_in;
         highest_plus_one_ff <= highest_plus_one_in;
         error_latched_ff    <= error_latched_in;
         if (csr_valid) begin
            mem_size_ff <= csr_mem_size;
         end
      end
   end

endmodule
`default_nettype wire

/* src/intel_hex_record_parser.sv */
`default_nettype none
//----------------------------------------------------------------------------
// intel_hex_record_parser
// Streaming hex record parser: characters in, memory writes and an end
// report out, with a front, a record engine and a queue after each.
//
//   channel   direction  handshake              payload
//   req_      in         req_push / req_full    req_cmd, req_ch
//   rsp_      out        rsp_pop / rsp_empty    kind, address, data, size, error
//   csr_      in         csr_valid / csr_ready  csr_mem_size
//
// one item per cycle sustained while the result side is not stalled; the
// record engine updates its line state once per character.
// a result reaches the rsp_ ports through the registered character queue,
// the record engine and the registered result queue.
// reset is synchronous and clears all state but the queue storage; the size
// register returns to 65536. csr_ready is always high.
// a stalled result side fills the result queue, then the character queue,
// then raises req_full.
//----------------------------------------------------------------------------
module intel_hex_record_parser (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic                          req_cmd,
   input  wire logic [ihex_pkg::CH_W-1:0]     req_ch,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic                               rsp_kind,
   output logic      [ihex_pkg::ADDR_W-1:0]   rsp_address,
   output logic      [ihex_pkg::DATA_W-1:0]   rsp_data,
   output logic      [ihex_pkg::SIZE_W-1:0]   rsp_size,
   output logic                               rsp_error,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ihex_pkg::SIZE_W-1:0]   csr_mem_size
);
   import ihex_pkg::*;

   logic          front_push;
   char_item_type front_item;
   char_item_type char_item;
   logic          char_empty;
   logic          char_pop;
   logic          out_full;
   logic          out_push;
   rsp_item_type  out_item;
   rsp_item_type  head_item;

   ihex_front u_front (
      .req_push  (req_push),
      .req_cmd   (req_cmd),
      .req_ch    (req_ch),
      .item_push (front_push),
      .item      (front_item)
   );

   ihex_fifo #(
      .WIDTH ($bits(char_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_char_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .wr_data (front_item),
      .full    (req_full),
      .pop     (char_pop),
      .rd_data (char_item),
      .empty   (char_empty)
   );

   ihex_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_mem_size (csr_mem_size),
      .char_item    (char_item),
      .char_empty   (char_empty),
      .char_pop     (char_pop),
      .rsp_full     (out_full),
      .rsp_push     (out_push),
      .rsp_item     (out_item)
   );

   ihex_fifo #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_item),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (head_item),
      .empty   (rsp_empty)
   );

   assign rsp_kind    = head_item.kind;
   assign rsp_address = head_item.address;
   assign rsp_data    = head_item.data;
   assign rsp_size    = head_item.size;
   assign rsp_error   = head_item.error;

endmodule
`default_nettype wire
